### rtl/thvn_pkg.sv
`default_nettype none
package thvn_pkg;

    localparam int COORD_FRAC_BITS = 8;
    localparam int COLUMN_HEIGHT   = 32;

    localparam int NUM_LAYERS = 6;
    localparam int NOISE_W    = 25;   // Q1.23 noise plus sign headroom
    localparam int FAC_W      = 25;   // Q0.24 factor, one included
    localparam int HALF23     = 1 << 23;

    // layer order
    localparam int LYR_CONT   = 0;
    localparam int LYR_BROAD  = 1;
    localparam int LYR_ROLL   = 2;
    localparam int LYR_DETAIL = 3;
    localparam int LYR_RIDGE  = 4;
    localparam int LYR_VALLEY = 5;

    localparam int unsigned LAYER_WAVELENGTH [NUM_LAYERS] = '{256, 112, 46, 18, 92, 176};
    localparam logic [63:0] LAYER_SALT [NUM_LAYERS] = '{
        64'h2f6e2b1d54a32f71, 64'hb43ac574127b3b55, 64'h9642a7c13d42e0bd,
        64'h6f54789be80a9d2b, 64'he290a3ac986dc3d7, 64'h47dfd298cba61d31
    };

    localparam logic [63:0] K_GOLD = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] K_MIX1 = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] K_MIX2 = 64'h94d049bb133111eb;
    localparam logic [63:0] K_ZMUL = 64'hc2b2ae3d27d4eb4f;

    // ridge band, valley band edges (Q1.23)
    localparam int unsigned BAND_EDGE0 [2] = '{3187671, 4697620};
    localparam int unsigned BAND_EDGE1 [2] = '{7214203, 7885292};

    // doubled Q.16 weights of cont, broad, roll, detail
    localparam int unsigned NOISE_WEIGHT2 [4] = '{524288, 445644, 275252, 91750};
    localparam int unsigned RIDGE_WEIGHT  = 314573;
    localparam int unsigned VALLEY_BASE_W = 209715;
    localparam int unsigned VALLEY_RIDGE_W = 111411;
    localparam int          HEIGHT_BASE   = 11;

    localparam int HEIGHT_LO     = 2 * 256;
    localparam int HEIGHT_HI_RAW = (COLUMN_HEIGHT - 3) * 256;
    localparam int HEIGHT_HI     = (HEIGHT_HI_RAW > 8191) ? 8191 : HEIGHT_HI_RAW;

endpackage
`default_nettype wire

### rtl/thvn_layer.sv
`default_nettype none
module thvn_layer #(
    parameter int unsigned LAYER = 0
) (
    input  wire logic                                clk,
    input  wire logic [63:0]                         seed,
    input  wire logic signed [31:0]                  pos_x,
    input  wire logic signed [31:0]                  pos_z,
    output logic signed [thvn_pkg::NOISE_W-1:0]      noise
);
    import thvn_pkg::*;

    localparam longint unsigned WAVE   = 64'(LAYER_WAVELENGTH[LAYER]) << COORD_FRAC_BITS;
    localparam int              RW     = $clog2(WAVE);
    localparam longint unsigned RECIP  = (64'd1 << 32) / WAVE;
    localparam longint unsigned FRECIP = (64'd1 << (24 + RW)) / WAVE;
    localparam int              FPW    = RW + 26;
    localparam int              CW     = RW + 25;
    localparam logic [63:0]     SALT   = LAYER_SALT[LAYER];

    logic [31:0]             pos_in [2];
    logic [63:0]             cprod  [2][2];   // [axis][offset]
    logic [FAC_W-1:0]        fade_s [2];      // tx at stage 11, tz at stage 13
    logic signed [NOISE_W-1:0] corner [2][2]; // [x off][z off], stage 11
    logic [63:0]             seed_salt;

    assign pos_in[0] = pos_x;
    assign pos_in[1] = pos_z;
    assign seed_salt = seed ^ SALT;

    for (genvar ax = 0; ax < 2; ax++) begin : g_axis
        localparam logic [63:0] KC  = (ax == 0) ? K_GOLD : K_ZMUL;
        localparam int          DLY = (ax == 0) ? 3 : 5;

        logic        neg_1_reg, neg_2_reg;
        logic [30:0] mag_1_reg, qe_1_reg, qe_2_reg;
        logic [31:0] rr_2_reg;
        logic [31:0] cell_3_reg;
        logic [RW-1:0] rem_3_reg, rem_4_reg;
        logic [23:0] est_4_reg, est_5_reg;
        logic [RW:0] chk_5_reg;
        logic [23:0] frac_6_reg;
        logic [23:0] t_7_reg, t2_7_reg;
        logic [FAC_W-1:0] s_8_reg;
        logic [FAC_W-1:0] sd_reg [DLY];
        logic [63:0] pl_4_reg;
        logic [31:0] ph_4_reg;
        logic        wrap_4_reg;
        logic [63:0] cp0_5_reg, cp1_5_reg;

        logic [30:0] mag_in;
        logic [62:0] qprod;
        logic [31:0] qw;
        logic        fix3;
        logic [30:0] q3;
        logic [31:0] r3;
        logic [FPW-1:0] fprod;
        logic [CW-1:0]  chk;
        logic [47:0] tsq;
        logic [25:0] fmul;
        logic [49:0] fprod2;
        logic [63:0] pl, ph, cp0;

        always_comb
        begin
            mag_in = pos_in[ax][31] ? ~pos_in[ax][30:0] : pos_in[ax][30:0];
            qprod  = 63'(mag_in) * 63'(RECIP);
            qw     = 32'(qe_1_reg) * 32'(WAVE);
            fix3   = rr_2_reg >= 32'(WAVE);
            q3     = qe_2_reg + 31'(fix3);
            r3     = fix3 ? rr_2_reg - 32'(WAVE) : rr_2_reg;
            fprod  = FPW'(rem_3_reg) * FPW'(FRECIP);
            chk    = (CW'(rem_4_reg) << 24) - CW'(est_4_reg) * CW'(WAVE);
            tsq    = 48'(frac_6_reg) * 48'(frac_6_reg);
            fmul   = 26'(3 << 24) - {1'b0, t_7_reg, 1'b0};
            fprod2 = 50'(t2_7_reg) * 50'(fmul);
            pl     = 64'(cell_3_reg) * 64'(KC[31:0]);
            ph     = 64'(cell_3_reg) * 64'(KC[63:32]);
            cp0    = pl_4_reg + {ph_4_reg, 32'd0};
        end

        always_ff @(posedge clk)
        begin
            // floor division by the cell width, magnitude form
            neg_1_reg  <= pos_in[ax][31];
            mag_1_reg  <= mag_in;
            qe_1_reg   <= qprod[62:32];
            neg_2_reg  <= neg_1_reg;
            qe_2_reg   <= qe_1_reg;
            rr_2_reg   <= {1'b0, mag_1_reg} - qw;
            cell_3_reg <= neg_2_reg ? ~{1'b0, q3} : {1'b0, q3};
            rem_3_reg  <= neg_2_reg ? RW'(WAVE - 1) - r3[RW-1:0] : r3[RW-1:0];
            // fraction = rem * 2^24 / W
            rem_4_reg  <= rem_3_reg;
            est_4_reg  <= fprod[RW+23:RW];
            est_5_reg  <= est_4_reg;
            chk_5_reg  <= chk[RW:0];
            frac_6_reg <= est_5_reg + 24'(chk_5_reg >= (RW+1)'(WAVE));
            // smoothstep
            t_7_reg    <= frac_6_reg;
            t2_7_reg   <= tsq[47:24];
            s_8_reg    <= fprod2[48:24];
            sd_reg[0]  <= s_8_reg;
            for (int i = 1; i < DLY; i++)
            begin
                sd_reg[i] <= sd_reg[i-1];
            end
            // coordinate products; cell+1 wraps to zero past all ones
            pl_4_reg   <= pl;
            ph_4_reg   <= ph[31:0];
            wrap_4_reg <= &cell_3_reg;
            cp0_5_reg  <= cp0;
            cp1_5_reg  <= wrap_4_reg ? 64'd0 : cp0 + KC;
        end

        assign cprod[ax][0] = cp0_5_reg;
        assign cprod[ax][1] = cp1_5_reg;
        assign fade_s[ax]   = sd_reg[DLY-1];
    end

    for (genvar ci = 0; ci < 4; ci++) begin : g_corner
        localparam int IX = ci % 2;
        localparam int IZ = ci / 2;

        logic [63:0] x_6_reg;
        logic [63:0] ll_7_reg, ll_9_reg;
        logic [31:0] lh_7_reg, hl_7_reg, lh_9_reg, hl_9_reg;
        logic [63:0] y_8_reg;
        logic [23:0] v_10_reg;
        logic signed [NOISE_W-1:0] c_11_reg;

        logic [63:0] xm, x0;
        logic [63:0] ll1, lh1, hl1, y, ll2, lh2, hl2, z;

        always_comb
        begin
            xm  = seed_salt ^ cprod[0][IX] ^ cprod[1][IZ];
            x0  = xm + K_GOLD;
            ll1 = 64'(x_6_reg[31:0]) * 64'(K_MIX1[31:0]);
            lh1 = 64'(x_6_reg[31:0]) * 64'(K_MIX1[63:32]);
            hl1 = 64'(x_6_reg[63:32]) * 64'(K_MIX1[31:0]);
            y   = ll_7_reg + {lh_7_reg + hl_7_reg, 32'd0};
            ll2 = 64'(y_8_reg[31:0]) * 64'(K_MIX2[31:0]);
            lh2 = 64'(y_8_reg[31:0]) * 64'(K_MIX2[63:32]);
            hl2 = 64'(y_8_reg[63:32]) * 64'(K_MIX2[31:0]);
            z   = ll_9_reg + {lh_9_reg + hl_9_reg, 32'd0};
        end

        always_ff @(posedge clk)
        begin
            x_6_reg  <= x0 ^ (x0 >> 30);
            ll_7_reg <= ll1;
            lh_7_reg <= lh1[31:0];
            hl_7_reg <= hl1[31:0];
            y_8_reg  <= y ^ (y >> 27);
            ll_9_reg <= ll2;
            lh_9_reg <= lh2[31:0];
            hl_9_reg <= hl2[31:0];
            // the final xor with z >> 31 leaves bits 63..40 untouched
            v_10_reg <= z[63:40];
            // v * 2^24 / (2^24 - 1) is v, except all ones maps to 2^24
            c_11_reg <= $signed(25'({1'b0, v_10_reg} + 25'(&v_10_reg)) - 25'(HALF23));
        end

        assign corner[IX][IZ] = c_11_reg;
    end

    // bilinear blend: along x, then along z
    logic signed [25:0] dx [2];
    logic signed [51:0] px [2];
    logic signed [25:0] dz;
    logic signed [51:0] pz;
    logic signed [25:0] tx_s, tz_s;
    logic signed [25:0] dlt_12_reg [2];
    logic signed [NOISE_W-1:0] base_12_reg [2];
    logic signed [NOISE_W-1:0] edge_13_reg [2];
    logic signed [25:0] dlt_14_reg;
    logic signed [NOISE_W-1:0] base_14_reg;
    logic signed [NOISE_W-1:0] noise_15_reg;
    logic signed [25:0] e_sum [2];
    logic signed [25:0] n_sum;

    always_comb
    begin
        tx_s = $signed({1'b0, fade_s[0]});
        tz_s = $signed({1'b0, fade_s[1]});
        for (int j = 0; j < 2; j++)
        begin
            dx[j]    = 26'(corner[1][j]) - 26'(corner[0][j]);
            px[j]    = dx[j] * tx_s;
            e_sum[j] = 26'(base_12_reg[j]) + dlt_12_reg[j];
        end
        dz    = 26'(edge_13_reg[1]) - 26'(edge_13_reg[0]);
        pz    = dz * tz_s;
        n_sum = 26'(base_14_reg) + dlt_14_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 2; j++)
        begin
            dlt_12_reg[j]  <= px[j][49:24];
            base_12_reg[j] <= corner[0][j];
            edge_13_reg[j] <= e_sum[j][NOISE_W-1:0];
        end
        dlt_14_reg   <= pz[49:24];
        base_14_reg  <= edge_13_reg[0];
        noise_15_reg <= n_sum[NOISE_W-1:0];
    end

    assign noise = noise_15_reg;

endmodule
`default_nettype wire

### rtl/terrain_height_value_noise.sv
`default_nettype none
// Terrain column height from six layers of value noise. One column (pos_x, pos_z) may be
// started in every clock cycle; busy never rises. Each item's result is driven on done for
// exactly one cycle and is taken at the edge that ends that cycle: the block has no output
// stall. The latency is set by the lattice hash, two 64-bit multiplies each split over
// partial-product and sum stages, followed by the blend stages and the band and height-sum
// stages. The seed is written through cfg_valid/cfg_ready with cfg_seed (ready is always
// high) and must only change while no item is in flight.
module terrain_height_value_noise (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [31:0] pos_x,
    input  wire logic signed [31:0] pos_z,
    output logic                    done,
    output logic [12:0]             ground_height,
    output logic [15:0]             valley_amount,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [63:0]        cfg_seed
);
    import thvn_pkg::*;

    localparam int LAT = 27;

    logic [63:0]        seed_reg;
    logic [LAT-1:0]     vld_reg;
    logic signed [31:0] px_0_reg, pz_0_reg;
    logic signed [NOISE_W-1:0] noise [NUM_LAYERS];
    logic [FAC_W-1:0]   fac [2];   // ridge, valley at stage 21

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign done      = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
            vld_reg  <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                seed_reg <= cfg_seed;
            end
            vld_reg <= {vld_reg[LAT-2:0], start};
        end
    end

    always_ff @(posedge clk)
    begin
        px_0_reg <= pos_x;
        pz_0_reg <= pos_z;
    end

    for (genvar k = 0; k < NUM_LAYERS; k++) begin : g_layer
        thvn_layer #(
            .LAYER (k)
        ) u_layer (
            .clk   (clk),
            .seed  (seed_reg),
            .pos_x (px_0_reg),
            .pos_z (pz_0_reg),
            .noise (noise[k])
        );
    end

    // ridge and valley: smoothstep over a band of 2^23 - |n|
    for (genvar b = 0; b < 2; b++) begin : g_band
        localparam longint unsigned E0     = 64'(BAND_EDGE0[b]);
        localparam longint unsigned BWIDTH = 64'(BAND_EDGE1[b]) - E0;
        localparam int              DW     = $clog2(BWIDTH + 1);
        localparam longint unsigned BRECIP = (64'd1 << (24 + DW)) / BWIDTH;
        localparam int              BPW    = DW + 26;
        localparam int              CW     = DW + 25;

        logic [DW-1:0] d_16_reg, d_17_reg;
        logic [24:0]   est_17_reg, est_18_reg;
        logic [DW:0]   chk_18_reg;
        logic [24:0]   t_19_reg, t_20_reg, t2_20_reg;
        logic [24:0]   s_21_reg;

        logic signed [NOISE_W-1:0] n;
        logic [23:0]  absn, src, dsub;
        logic [BPW-1:0] bprod;
        logic [CW-1:0]  chk;
        logic [49:0]  tsq;
        logic [25:0]  fmul;
        logic [50:0]  fprod;

        always_comb
        begin
            n     = noise[LYR_RIDGE + b];
            absn  = n[NOISE_W-1] ? 24'(-n) : 24'(n);
            src   = 24'(HALF23) - absn;
            dsub  = src - 24'(E0);
            bprod = BPW'(d_16_reg) * BPW'(BRECIP);
            chk   = (CW'(d_17_reg) << 24) - CW'(est_17_reg) * CW'(BWIDTH);
            tsq   = 50'(t_19_reg) * 50'(t_19_reg);
            fmul  = 26'(3 << 24) - {t_20_reg, 1'b0};
            fprod = 51'(t2_20_reg) * 51'(fmul);
        end

        always_ff @(posedge clk)
        begin
            if (src < 24'(E0))
            begin
                d_16_reg <= '0;
            end
            else if (dsub > 24'(BWIDTH))
            begin
                d_16_reg <= DW'(BWIDTH);
            end
            else
            begin
                d_16_reg <= dsub[DW-1:0];
            end
            d_17_reg   <= d_16_reg;
            est_17_reg <= bprod[DW+24:DW];
            est_18_reg <= est_17_reg;
            chk_18_reg <= chk[DW:0];
            t_19_reg   <= est_18_reg + 25'(chk_18_reg >= (DW+1)'(BWIDTH));
            t_20_reg   <= t_19_reg;
            t2_20_reg  <= tsq[48:24];
            s_21_reg   <= fprod[48:24];
        end

        assign fac[b] = s_21_reg;
    end

    // plain noise layers wait for the band factors
    logic signed [NOISE_W-1:0] nd [4];
    for (genvar k = 0; k < 4; k++) begin : g_ndly
        logic signed [NOISE_W-1:0] dly_reg [6];
        always_ff @(posedge clk)
        begin
            dly_reg[0] <= noise[k];
            for (int i = 1; i < 6; i++)
            begin
                dly_reg[i] <= dly_reg[i-1];
            end
        end
        assign nd[k] = dly_reg[5];
    end

    logic [24:0]  rsq_22_reg;
    logic [18:0]  frw_22_reg;
    logic [24:0]  f_22_reg, f_23_reg, f_24_reg;
    logic signed [NOISE_W-1:0] nd_22_reg [4];
    logic signed [47:0] pn_23_reg [4];
    logic [47:0]  pr_23_reg, pf_23_reg;
    logic signed [47:0] sa_24_reg, sb_24_reg;
    logic signed [15:0] hq_25_reg;
    logic [15:0]  vly_25_reg;
    logic [12:0]  height_26_reg;
    logic [15:0]  valley_26_reg;

    logic [49:0]  rr;
    logic [41:0]  rw;
    logic signed [47:0] pn [4];
    logic signed [47:0] h;
    logic [40:0]  vw;
    logic signed [15:0] hi_s, lo_s;

    always_comb
    begin
        rr = 50'(fac[0]) * 50'(fac[0]);
        rw = 42'(VALLEY_RIDGE_W) * 42'(fac[0]);
        for (int k = 0; k < 4; k++)
        begin
            pn[k] = nd_22_reg[k] * $signed(22'(NOISE_WEIGHT2[k]));
        end
        h    = sa_24_reg + sb_24_reg;
        vw   = {f_24_reg, 16'd0} - 41'(f_24_reg);
        hi_s = $signed(16'(HEIGHT_HI));
        lo_s = $signed(16'(HEIGHT_LO));
    end

    always_ff @(posedge clk)
    begin
        rsq_22_reg <= rr[48:24];
        frw_22_reg <= 19'(VALLEY_BASE_W) + 19'(rw[41:24]);
        f_22_reg   <= fac[1];
        nd_22_reg  <= nd;

        pn_23_reg  <= pn;
        pr_23_reg  <= 48'(rsq_22_reg) * 48'(RIDGE_WEIGHT);
        pf_23_reg  <= 48'(f_22_reg) * 48'(frw_22_reg);
        f_23_reg   <= f_22_reg;

        sa_24_reg  <= (48'(HEIGHT_BASE) << 40) + pn_23_reg[LYR_CONT] + pn_23_reg[LYR_BROAD]
                      + pn_23_reg[LYR_ROLL];
        sb_24_reg  <= pn_23_reg[LYR_DETAIL] + $signed(pr_23_reg) - $signed(pf_23_reg);
        f_24_reg   <= f_23_reg;

        hq_25_reg  <= h[47:32];
        vly_25_reg <= vw[39:24];

        if (hq_25_reg > hi_s)
        begin
            height_26_reg <= 13'(HEIGHT_HI);
        end
        else if (hq_25_reg < lo_s)
        begin
            height_26_reg <= 13'(HEIGHT_LO);
        end
        else
        begin
            height_26_reg <= hq_25_reg[12:0];
        end
        valley_26_reg <= vly_25_reg;
    end

    assign ground_height = height_26_reg;
    assign valley_amount = valley_26_reg;

endmodule
`default_nettype wire
